@@ sv/fhp_pkg.sv @@
// Shared constants, types and the color palette of the fire heat block.
`default_nettype none

package fhp_pkg;

  // Field size and geometry.
  localparam int unsigned Width    = 256;
  localparam int unsigned Rows     = 64;
  localparam int unsigned ColW     = $clog2(Width);
  localparam int unsigned RowW     = $clog2(Rows);
  localparam int unsigned Depth    = Width * Rows;
  localparam int unsigned AddrW    = RowW + ColW;
  localparam int unsigned HeatW    = 8;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned NibW     = 4;
  localparam int unsigned ThrW     = 5;
  localparam int unsigned SumW     = HeatW + 2;
  localparam int unsigned ProdW    = 2 * SumW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CfgHotThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgActiveRows   = CfgIdxW'(1);
  localparam logic [ThrW-1:0]    ThrReset        = ThrW'(9);
  localparam logic [RowW-1:0]    RowsReset       = RowW'(60);

  localparam logic [ColW-1:0]  ColLast = ColW'(Width - 1);
  localparam logic [HeatW-1:0] HeatMax = HeatW'(255);

  // Division by three as a multiply by 683 and a shift by 11, exact below 1024.
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;

  // One word entering the pipeline.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            hot;
    logic            cur_ok;
    logic            last;
  } fhp_item_t;

  // Write of a new heat value into the store.
  typedef struct packed {
    logic             we;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [HeatW-1:0] data;
  } fhp_wr_t;

  // Fire palette: black to blue, to red, to yellow, to white.
  function automatic logic [ColorW-1:0] palette_color(input logic [HeatW-1:0] h);
    logic [7:0]        k;
    logic [ColorW-1:0] c;
    k = {3'b000, h[4:0]};
    case (h[7:5])
      3'd0:    c = {8'h00, 8'h00, 8'(k << 1), 8'h00};
      3'd1:    c = {8'(k << 3), 8'h00, 8'(8'd64 - 8'(k << 1)), 8'h00};
      3'd2:    c = {8'hFF, 8'(k << 3), 8'h00, 8'h00};
      3'd3:    c = {8'hFF, 8'hFF, 8'(k << 2), 8'h00};
      3'd4:    c = {8'hFF, 8'hFF, 8'(8'd64 + 8'(k << 2)), 8'h00};
      3'd5:    c = {8'hFF, 8'hFF, 8'(8'd128 + 8'(k << 2)), 8'h00};
      3'd6:    c = {8'hFF, 8'hFF, 8'(8'd192 + k), 8'h00};
      default: c = {8'hFF, 8'hFF, 8'(8'd224 + k), 8'h00};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/fhp_in_if.sv @@
// Input channel carrying one random nibble per word.
`default_nettype none

interface fhp_in_if import fhp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [NibW-1:0] random_nibble;

  modport source (output valid, output random_nibble, input ready);
  modport sink (input valid, input random_nibble, output ready);
endinterface

`default_nettype wire

@@ sv/fhp_out_if.sv @@
// Output channel carrying one updated cell per word.
`default_nettype none

interface fhp_out_if import fhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RowW-1:0]   cell_row;
  logic [ColW-1:0]   cell_column;
  logic [HeatW-1:0]  heat;
  logic [ColorW-1:0] pixel_color;
  logic              frame_last;

  modport source (output valid, output cell_row, output cell_column, output heat,
                  output pixel_color, output frame_last, input ready);
  modport sink (input valid, input cell_row, input cell_column, input heat,
                input pixel_color, input frame_last, output ready);
endinterface

`default_nettype wire

@@ sv/fhp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fhp_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [DataW-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/fhp_seq.sv @@
// Sequencer: configuration registers, row and column counters, store addresses.
`default_nettype none

module fhp_seq import fhp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                acc_i,
  input  wire logic [NibW-1:0]     nibble_i,
  input  wire fhp_wr_t             wr_i,
  output fhp_item_t                item_o,
  output logic      [AddrW-1:0]    cur_addr_o,
  output logic      [AddrW-1:0]    look_addr_o
);

  logic [ThrW-1:0]  thr_q;
  logic [RowW-1:0]  rows_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [Rows-1:0]  row_ok_q;
  logic             row_end;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrReset;
      rows_q <= RowsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHotThreshold: thr_q  <= cfg_data_i[ThrW-1:0];
        CfgActiveRows:   rows_q <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // Position of the next word in the frame.
  assign row_end = (col_q == ColLast) && (row_q >= rows_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (col_q == ColLast) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // A row counts as written once its last column has been stored; before that
  // its old values read as zero, which stands in for clearing the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
    end else if (wr_i.we && (wr_i.col == ColLast)) begin
      row_ok_q[wr_i.row] <= 1'b1;
    end
  end

  // Word descriptor handed to the pipeline.
  always_comb begin
    item_o.row    = row_q;
    item_o.col    = col_q;
    item_o.hot    = {1'b0, nibble_i} >= thr_q;
    item_o.cur_ok = row_ok_q[row_q];
    item_o.last   = row_end;
  end

  // The old cell itself, and the look-ahead cell of the row below. At the last
  // column the look-ahead fetches column zero of this row for the next row.
  assign cur_addr_o = {row_q, col_q};
  always_comb begin
    if (col_q == ColLast) begin
      look_addr_o = {row_q, ColW'(0)};
    end else begin
      look_addr_o = {row_q - RowW'(1), col_q + ColW'(1)};
    end
  end

`ifndef SYNTHESIS
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (col_q == ColLast) |=> col_q == '0)
    else $error("column counter did not wrap at the end of a row");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (col_q != ColLast) |=> row_q == $past(row_q))
    else $error("row counter moved inside a row");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && row_end |=> row_q == '0)
    else $error("row counter did not return to the bottom row at frame end");
`endif

endmodule

`default_nettype wire

@@ sv/fhp_core.sv @@
// Update pipeline: neighbor window and sum, divide and cool, palette, output.
`default_nettype none

module fhp_core import fhp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fhp_item_t        item_i,
  input  wire logic [HeatW-1:0] look_rd_i,
  input  wire logic [HeatW-1:0] cur_rd_i,
  output fhp_wr_t               wr_o,
  fhp_out_if.source             out_o
);

  logic rdy1, rdy2, rdy3, rdy_o;

  // Stage 1: store data arrives.
  logic             v1_q;
  fhp_item_t        it1_q;
  logic [HeatW-1:0] wa_q, wb_q;
  logic [HeatW-1:0] cur1;
  logic [SumW-1:0]  sum1;

  // Stage 2: divide, cool, seed.
  logic             v2_q;
  logic [SumW-1:0]  sum2_q;
  logic             border2_q;
  logic [RowW-1:0]  row2_q;
  logic [ColW-1:0]  col2_q;
  logic             hot2_q;
  logic             last2_q;
  logic [ProdW-1:0] prod2;
  logic [HeatW-1:0] quot2;
  logic [HeatW-1:0] heat2;

  // Stage 3: palette.
  logic             v3_q;
  logic [RowW-1:0]  row3_q;
  logic [ColW-1:0]  col3_q;
  logic [HeatW-1:0] heat3_q;
  logic             last3_q;

  // Output register.
  logic              vo_q;
  logic [RowW-1:0]   rowo_q;
  logic [ColW-1:0]   colo_q;
  logic [HeatW-1:0]  heato_q;
  logic [ColorW-1:0] coloro_q;
  logic              lasto_q;

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy_o      = !vo_q || out_o.ready;
  assign rdy3       = !v3_q || rdy_o;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  // Neighbor window over the row below: wa holds column c-1, wb column c, and
  // the look-ahead read brings column c+1. It shifts once per word.
  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      wa_q <= wb_q;
      wb_q <= look_rd_i;
    end
  end

  assign cur1 = it1_q.cur_ok ? cur_rd_i : '0;

  always_comb begin
    if (it1_q.col == '0) begin
      sum1 = SumW'(wb_q) + SumW'(look_rd_i) + SumW'(cur1);
    end else if (it1_q.col == ColLast) begin
      sum1 = SumW'(wb_q) + SumW'(wa_q) + SumW'(cur1);
    end else begin
      sum1 = SumW'(wb_q) + SumW'(wa_q) + SumW'(look_rd_i) + SumW'(cur1);
    end
  end

  // Border cells divide by three, inner cells by four; then cool by one if above one.
  assign prod2 = ProdW'(sum2_q) * ProdW'(Recip3);
  assign quot2 = border2_q ? HeatW'(prod2 >> Recip3Shift) : sum2_q[SumW-1:2];

  always_comb begin
    if (row2_q == '0) begin
      heat2 = hot2_q ? HeatMax : '0;
    end else if (quot2 > HeatW'(1)) begin
      heat2 = quot2 - HeatW'(1);
    end else begin
      heat2 = quot2;
    end
  end

  // Store the new heat as the word leaves stage 2.
  always_comb begin
    wr_o.we   = v2_q && rdy3;
    wr_o.row  = row2_q;
    wr_o.col  = col2_q;
    wr_o.data = heat2;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      it1_q <= item_i;
    end
    if (rdy2) begin
      sum2_q    <= sum1;
      border2_q <= (it1_q.col == '0) || (it1_q.col == ColLast);
      row2_q    <= it1_q.row;
      col2_q    <= it1_q.col;
      hot2_q    <= it1_q.hot;
      last2_q   <= it1_q.last;
    end
    if (rdy3) begin
      row3_q  <= row2_q;
      col3_q  <= col2_q;
      heat3_q <= heat2;
      last3_q <= last2_q;
    end
    if (rdy_o) begin
      rowo_q   <= row3_q;
      colo_q   <= col3_q;
      heato_q  <= heat3_q;
      coloro_q <= palette_color(heat3_q);
      lasto_q  <= last3_q;
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.cell_row    = rowo_q;
  assign out_o.cell_column = colo_q;
  assign out_o.heat        = heato_q;
  assign out_o.pixel_color = coloro_q;
  assign out_o.frame_last  = lasto_q;

`ifndef SYNTHESIS
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && lasto_q |-> colo_q == ColLast)
    else $error("frame end flagged away from the last column");

  a_seed_heat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && (rowo_q == '0) |-> (heato_q == '0) || (heato_q == HeatMax))
    else $error("seeded bottom cell is neither cold nor hot");

  a_cooled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && (rowo_q != '0) |-> heato_q != HeatMax)
    else $error("propagated cell was not cooled");
`endif

endmodule

`default_nettype wire

@@ sv/fire_heat_propagation.sv @@
// Top level of the fire heat propagation block.
//
// Each word accepted on in_i is one cell update slot. A frame first seeds the
// bottom row, one column per word, from random_nibble against hot_threshold,
// then updates rows 1 to active_rows from the row below and the cell's old
// heat. Every word yields exactly one word on out_o: row, column, new heat,
// its palette color, and frame_last on the last cell of the frame.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle; index 0 is hot_threshold, index 1 is active_rows.
// An accepted word passes the stage 1, 2, 3 and output registers on its way
// to out_o. Throughput: one word per cycle unless out_o stalls, set by the
// four-stage pipeline and one read of each of two store copies per word.
// Reset clears the counters and the pipeline; rows read as cold until they
// have been written once, so no clearing pass is needed and a word may enter
// in the first cycle after reset. When the receiver stalls, the output word
// holds and bubbles in the pipeline still fill; in_i.ready drops only once
// every stage is occupied.
`default_nettype none

module fire_heat_propagation import fhp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fhp_in_if.sink                   in_i,
  fhp_out_if.source                out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic             in_ready;
  logic             in_acc;
  fhp_item_t        item;
  fhp_wr_t          wr;
  logic [AddrW-1:0] cur_addr;
  logic [AddrW-1:0] look_addr;
  logic [HeatW-1:0] cur_rd;
  logic [HeatW-1:0] look_rd;

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  fhp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (in_acc),
    .nibble_i    (in_i.random_nibble),
    .wr_i        (wr),
    .item_o      (item),
    .cur_addr_o  (cur_addr),
    .look_addr_o (look_addr)
  );

  // Two copies of the heat store, written alike, one per read port.
  fhp_ram #(
    .DataW (HeatW),
    .Depth (Depth)
  ) u_ram_cur (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i ({wr.row, wr.col}),
    .wdata_i (wr.data),
    .re_i    (in_acc),
    .raddr_i (cur_addr),
    .rdata_o (cur_rd)
  );

  fhp_ram #(
    .DataW (HeatW),
    .Depth (Depth)
  ) u_ram_look (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i ({wr.row, wr.col}),
    .wdata_i (wr.data),
    .re_i    (in_acc),
    .raddr_i (look_addr),
    .rdata_o (look_rd)
  );

  fhp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .item_i     (item),
    .look_rd_i  (look_rd),
    .cur_rd_i   (cur_rd),
    .wr_o       (wr),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the fire heat propagation block.

module testbench;
  import fhp_pkg::*;

  // Register indexes that the block does not decode; writes to them are dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = CfgIdxW'(3);

  // Number of randomized phases that follow the directed words.
  localparam int NumPhases = 7;

  typedef enum logic {SlotWord, SlotRegWrite} slot_kind_e;

  // One entry of the stimulus list: a nibble word or a register write.
  typedef struct {
    slot_kind_e          kind;
    logic [NibW-1:0]     nibble;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } slot_t;

  // One updated cell as the block should report it.
  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [HeatW-1:0]  heat;
    logic [ColorW-1:0] color;
    logic              last;
  } cell_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  fhp_in_if  in_if ();
  fhp_out_if out_if ();

  fire_heat_propagation u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the block: heat field, sweep position and registers.
  logic [HeatW-1:0] heat_field [Rows][Width] = '{default: '0};
  int unsigned      col_now = 0;
  int unsigned      row_now = 0;
  logic [ThrW-1:0]  thr_now = ThrReset;
  logic [RowW-1:0]  rows_now = RowsReset;

  slot_t pending_slots[$];
  cell_t expected_cells[$];

  int send_wait = 0;
  int send_run = 0;
  int hold_left = 0;
  int recv_run = 0;
  int cycles = 0;
  int cycle_limit = 0;
  int mismatches = 0;
  int words_predicted = 0;
  int seeds_hot = 0;
  int regs_written = 0;
  int cells_seen = 0;
  int frames_seen = 0;
  int deepest_row = 0;

  // Fire palette: blue ramp, blue to red, red to yellow, then toward white.
  function automatic logic [ColorW-1:0] fire_color(input logic [HeatW-1:0] h);
    logic [4:0] k;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    k = h[4:0];
    red = 8'h00;
    green = 8'h00;
    blue = 8'h00;
    case (h[7:5])
      3'd0: blue = {2'b00, k, 1'b0};
      3'd1: begin
        red = {k, 3'b000};
        blue = 8'd64 - {2'b00, k, 1'b0};
      end
      3'd2: begin
        red = 8'hFF;
        green = {k, 3'b000};
      end
      default: begin
        red = 8'hFF;
        green = 8'hFF;
        case (h[7:5])
          3'd3: blue = {1'b0, k, 2'b00};
          3'd4: blue = 8'd64 + {1'b0, k, 2'b00};
          3'd5: blue = 8'd128 + {1'b0, k, 2'b00};
          3'd6: blue = 8'd192 + {3'b000, k};
          default: blue = 8'd224 + {3'b000, k};
        endcase
      end
    endcase
    return {red, green, blue, 8'h00};
  endfunction

  // Update the cell under the sweep and queue the word the block must emit.
  function automatic void propagate_cell(input logic [NibW-1:0] nib);
    cell_t       upd;
    int unsigned lim;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned left;
    int unsigned mid;
    int unsigned right;
    int unsigned old;
    c = col_now;
    r = row_now;
    lim = (rows_now > Rows - 1) ? Rows - 1 : rows_now;
    if (r == 0) begin
      h = (nib >= thr_now) ? 255 : 0;
      if (h != 0) seeds_hot++;
    end else begin
      mid = heat_field[r-1][c];
      old = heat_field[r][c];
      left = (c == 0) ? 0 : heat_field[r-1][c-1];
      right = (c == Width - 1) ? 0 : heat_field[r-1][c+1];
      // Borders average three values, inner cells four.
      if (c == 0 || c == Width - 1) h = (left + mid + right + old) / 3;
      else h = (left + mid + right + old) >> 2;
      if (h > 1) h = h - 1;
    end
    heat_field[r][c] = HeatW'(h);
    upd.row = RowW'(r);
    upd.col = ColW'(c);
    upd.heat = HeatW'(h);
    upd.color = fire_color(HeatW'(h));
    upd.last = 1'b0;
    // Advance the sweep; the row limit is checked at the end of every row.
    if (c == Width - 1) begin
      col_now = 0;
      if (r >= lim) begin
        row_now = 0;
        upd.last = 1'b1;
      end else begin
        row_now = r + 1;
      end
    end else begin
      col_now = c + 1;
    end
    expected_cells.push_back(upd);
    words_predicted++;
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    case (idx)
      CfgHotThreshold: thr_now = data[ThrW-1:0];
      CfgActiveRows:   rows_now = data[RowW-1:0];
      default: ;
    endcase
  endfunction

  // Wait before the next word or result, drawn at random, with idle-free bursts.
  function automatic int pick_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input cell_t at);
    mismatches++;
    if (mismatches <= 40)
      $display("cycle %0d, cell row %0d col %0d: %s is %0h, expected %0h",
               cycles, at.row, at.col, what, got, want);
  endtask

  task automatic add_word(input logic [NibW-1:0] nib);
    slot_t s;
    s.kind = SlotWord;
    s.nibble = nib;
    s.idx = '0;
    s.data = '0;
    pending_slots.push_back(s);
  endtask

  task automatic add_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    slot_t s;
    s.kind = SlotRegWrite;
    s.nibble = '0;
    s.idx = idx;
    s.data = data;
    pending_slots.push_back(s);
  endtask

  // Input side: presents words, and performs register writes once the block has drained.
  always @(posedge clk) begin : drive_words
    logic                valid_nxt;
    logic [NibW-1:0]     nib_nxt;
    logic                we_nxt;
    logic [CfgIdxW-1:0]  idx_nxt;
    logic [CfgDataW-1:0] data_nxt;
    slot_t               s;
    valid_nxt = in_if.valid;
    nib_nxt = in_if.random_nibble;
    we_nxt = 1'b0;
    idx_nxt = cfg_idx;
    data_nxt = cfg_data;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        propagate_cell(in_if.random_nibble);
        valid_nxt = 1'b0;
      end
      if (!valid_nxt) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_slots.size() != 0) begin
          s = pending_slots[0];
          if (s.kind == SlotWord) begin
            valid_nxt = 1'b1;
            nib_nxt = s.nibble;
            void'(pending_slots.pop_front());
            send_wait = pick_wait(send_run);
          end else if (expected_cells.size() == 0) begin
            // Every word yields a result, so an empty queue means the block is idle.
            we_nxt = 1'b1;
            idx_nxt = s.idx;
            data_nxt = s.data;
            apply_register(s.idx, s.data);
            regs_written++;
            void'(pending_slots.pop_front());
          end
        end
      end
    end
    in_if.valid <= valid_nxt;
    in_if.random_nibble <= nib_nxt;
    cfg_we <= we_nxt;
    cfg_idx <= idx_nxt;
    cfg_data <= data_nxt;
  end

  // Output side: stalls at random and checks every accepted cell word.
  always @(posedge clk) begin : watch_cells
    logic  ready_nxt;
    cell_t want;
    cell_t got;
    ready_nxt = out_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.row = out_if.cell_row;
        got.col = out_if.cell_column;
        got.heat = out_if.heat;
        got.color = out_if.pixel_color;
        got.last = out_if.frame_last;
        cells_seen++;
        if (out_if.frame_last === 1'b1) frames_seen++;
        if (int'(out_if.cell_row) > deepest_row) deepest_row = int'(out_if.cell_row);
        if (expected_cells.size() == 0) begin
          report_mismatch("word with nothing expected, heat", 32'(got.heat), 32'(0), got);
        end else begin
          want = expected_cells.pop_front();
          if (got.row !== want.row)
            report_mismatch("cell_row", 32'(got.row), 32'(want.row), want);
          if (got.col !== want.col)
            report_mismatch("cell_column", 32'(got.col), 32'(want.col), want);
          if (got.heat !== want.heat)
            report_mismatch("heat", 32'(got.heat), 32'(want.heat), want);
          if (got.color !== want.color)
            report_mismatch("pixel_color", got.color, want.color, want);
          if (got.last !== want.last)
            report_mismatch("frame_last", 32'(got.last), 32'(want.last), want);
        end
        hold_left = pick_wait(recv_run);
        ready_nxt = (hold_left == 0);
      end else if (!out_if.ready) begin
        if (hold_left > 0) hold_left--;
        ready_nxt = (hold_left == 0);
      end
    end
    out_if.ready <= ready_nxt;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycle_limit != 0 && cycles > cycle_limit) begin
      $display("timeout after %0d cycles with %0d cells still expected",
               cycles, expected_cells.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int rows_val;
    int thr_val;
    int count;
    in_if.valid = 1'b0;
    in_if.random_nibble = '0;
    out_if.ready = 1'b0;

    // Directed words: seeding against the threshold extremes and field extremes.
    add_reg(CfgHotThreshold, 6'd0);
    add_word(4'd0);
    add_word(4'd15);
    add_word(4'd7);
    add_reg(CfgHotThreshold, 6'd16);
    add_word(4'd15);
    add_word(4'd0);
    add_word(4'd15);
    add_reg(CfgHotThreshold, 6'd63);
    add_word(4'd15);
    add_reg(CfgHotThreshold, 6'd15);
    add_word(4'd15);
    add_word(4'd14);
    add_reg(CfgHotThreshold, 6'd1);
    add_word(4'd0);
    add_word(4'd1);
    // Writes to undecoded indexes must leave the threshold at one.
    add_reg(CfgSpareLow, 6'd0);
    add_reg(CfgSpareHigh, 6'd63);
    add_word(4'd15);
    add_word(4'd0);
    add_reg(CfgHotThreshold, 6'd8);
    add_word(4'd5);
    add_word(4'd10);

    // Random phases: a two-row frame that runs into its second row, a seed-only
    // limit dropped in while the sweep is above it, the deepest setting, and
    // short phases at a limit of two and at random limits.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: rows_val = 1;
        1: rows_val = 0;
        2: rows_val = 63;
        3: rows_val = 2;
        default: rows_val = $urandom_range(0, 63);
      endcase
      if ($urandom_range(0, 7) == 0) thr_val = $urandom_range(0, 63);
      else thr_val = $urandom_range(0, 16);
      case (p)
        0: count = 480;
        1: count = 24;
        default: count = $urandom_range(2, 8);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        add_reg(CfgActiveRows, CfgDataW'(rows_val));
        add_reg(CfgHotThreshold, CfgDataW'(thr_val));
      end else begin
        add_reg(CfgHotThreshold, CfgDataW'(thr_val));
        add_reg(CfgActiveRows, CfgDataW'(rows_val));
      end
      for (int i = 0; i < count; i++) add_word(NibW'($urandom_range(0, 15)));
    end
    cycle_limit = 5000 + pending_slots.size() * 80;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_slots.size() != 0 || in_if.valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d cell updates over %0d finished frames, %0d bottom cells seeded hot.",
             cells_seen, frames_seen, seeds_hot);
    $display("Register writes: %0d; deepest row updated: %0d; mismatches: %0d.",
             regs_written, deepest_row, mismatches);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
